// File: hw/rtl/periodic_poll_scheduler_macros.svh
// Assertion macros shared by the poll scheduler checker
`ifndef PERIODIC_POLL_SCHEDULER_MACROS_SVH
`define PERIODIC_POLL_SCHEDULER_MACROS_SVH
// implication checked on every clock edge out of reset
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/pps_pkg.sv
// Package for the periodic poll scheduler: sizes, codes and types
`default_nettype none
package pps_pkg;
	localparam int WatchSlots = 16;
	localparam int SlotW = $clog2(WatchSlots);
	localparam int CntW = $clog2(WatchSlots + 1);
	localparam logic [7:0] TouchWords = 8'd3;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_EN   = 2'd2,
		MODE_BAD  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_PAGE   = 3'd0,
		KIND_TOUCH  = 3'd1,
		KIND_WATCH  = 3'd2,
		KIND_WAIT   = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [2:0] REG_PAGE_ON     = 3'd0;
	localparam logic [2:0] REG_PAGE_PERIOD = 3'd1;
	localparam logic [2:0] REG_TOUCH_ON    = 3'd2;
	localparam logic [2:0] REG_TOUCH_PER   = 3'd3;
	localparam logic [2:0] REG_BUDGET      = 3'd4;
	localparam logic [2:0] REG_DEF_WAIT    = 3'd5;
	localparam logic [2:0] REG_TOUCH_ADDR  = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PAGE,
		S_TOUCH,
		S_RR_RD,
		S_RR_CHK,
		S_MW_RD,
		S_MW_CHK,
		S_WAIT,
		S_EN_RD,
		S_EN_CHK,
		S_STATUS,
		S_HOLD
	} state_t;

	// signed wraparound due test
	function automatic logic is_due(input logic [31:0] now, input logic [31:0] due);
		logic [31:0] d;
		d = now - due;
		return ~d[31];
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/periodic_poll_scheduler.sv
// Top level of the periodic poll scheduler
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | mode now_time watch_addr watch_words watch_period ...
//  out     | out_valid | out_ready | kind req_addr req_words wait_time status last
//  cfg     | cfg_valid | cfg_ready | cfg_index cfg_data
// One item at a time. A tick visits entries round-robin (at most slots_used, cut short by
// the budget), then scans all used entries for the shortest wait. Add goes straight to its
// status result; enable searches in order for a matching address. No clearing pass after reset.
// The table has one read and one write port (one read per entry visit). Output stalls hold
// the sequencer; results do not while the receiver is ready.
`default_nettype none
module periodic_poll_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] now_time,
	input  wire logic [15:0] watch_addr,
	input  wire logic [7:0]  watch_words,
	input  wire logic [31:0] watch_period,
	input  wire logic        watch_on,
	input  wire logic        busy_hint,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      req_addr,
	output logic [7:0]       req_words,
	output logic [31:0]      wait_time,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int SW = pps_pkg::SlotW;
	localparam int CW = pps_pkg::CntW;
	localparam logic [CW-1:0] FullCnt = CW'(pps_pkg::WatchSlots);

	// entry memory: enable, addr, words, period, due
	logic [88:0] mem [pps_pkg::WatchSlots];
	logic [88:0] rd_s1;
	logic        mem_we;
	logic [SW-1:0] mem_wa, mem_ra;
	logic [88:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	// configuration registers
	logic        page_on_q, touch_on_q, page_armed_q, touch_armed_q;
	logic [31:0] page_per_q, touch_per_q, def_wait_q, page_due_q, touch_due_q;
	logic [7:0]  budget_q;
	logic [15:0] touch_addr_q;

	// item registers
	pps_pkg::state_t st_q, st_d;
	logic [1:0]  mode_q;
	logic [31:0] now_q, period_q, wait_q;
	logic [15:0] addr_q;
	logic [7:0]  words_q, left_q;
	logic        on_q, found_q;
	logic [CW-1:0] used_q, rr_q, idx_q, chk_q;
	logic [1:0]  stat_q;

	// output register
	logic        ov_q;
	logic [2:0]  kind_q;
	logic [15:0] raddr_q;
	logic [7:0]  rwords_q;
	logic [31:0] wt_q;
	logic [1:0]  ostat_q;
	logic        last_q;

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign req_addr = raddr_q;
	assign req_words = rwords_q;
	assign wait_time = wt_q;
	assign status = ostat_q;
	assign last = last_q;
	assign in_ready = (st_q == pps_pkg::S_IDLE);
	// registers change only when idle, empty and no transaction is offered
	assign cfg_ready = (st_q == pps_pkg::S_IDLE) && !ov_q && !in_valid;

	logic out_free;
	assign out_free = !ov_q || out_ready;

	// fields of the entry just read
	logic        e_en;
	logic [15:0] e_addr;
	logic [7:0]  e_words;
	logic [31:0] e_per, e_due, e_left;
	assign {e_en, e_addr, e_words, e_per, e_due} = rd_s1;
	assign e_left = pps_pkg::is_due(now_q, e_due) ? 32'd0 : e_due - now_q;

	logic [CW-1:0] rr_wrap;
	assign rr_wrap = (rr_q >= used_q) ? '0 : rr_q;

	logic page_fire, touch_fire;
	assign page_fire = page_on_q && (page_armed_q || pps_pkg::is_due(now_q, page_due_q));
	assign touch_fire = touch_on_q && (touch_armed_q || pps_pkg::is_due(now_q, touch_due_q));

	logic [31:0] pt, tt;
	assign pt = page_armed_q ? 32'd0 :
		(pps_pkg::is_due(now_q, page_due_q) ? 32'd0 : page_due_q - now_q);
	assign tt = touch_armed_q ? 32'd0 :
		(pps_pkg::is_due(now_q, touch_due_q) ? 32'd0 : touch_due_q - now_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pps_pkg::S_IDLE: if (in_valid) begin
				unique case (pps_pkg::mode_t'(mode))
					pps_pkg::MODE_TICK: st_d = pps_pkg::S_PAGE;
					pps_pkg::MODE_ADD:  st_d = pps_pkg::S_STATUS;
					pps_pkg::MODE_EN:   st_d = pps_pkg::S_EN_RD;
					default:            st_d = pps_pkg::S_STATUS;
				endcase
			end
			pps_pkg::S_PAGE:  if (out_free) st_d = pps_pkg::S_TOUCH;
			pps_pkg::S_TOUCH: if (out_free) st_d = pps_pkg::S_RR_RD;
			pps_pkg::S_RR_RD:
				st_d = (left_q != 8'd0 && chk_q < used_q) ? pps_pkg::S_RR_CHK
					: pps_pkg::S_MW_RD;
			pps_pkg::S_RR_CHK: if (out_free) st_d = pps_pkg::S_RR_RD;
			pps_pkg::S_MW_RD:
				st_d = (idx_q < used_q) ? pps_pkg::S_MW_CHK : pps_pkg::S_WAIT;
			pps_pkg::S_MW_CHK: st_d = pps_pkg::S_MW_RD;
			pps_pkg::S_WAIT:   if (out_free) st_d = pps_pkg::S_HOLD;
			pps_pkg::S_EN_RD:
				st_d = (idx_q < used_q) ? pps_pkg::S_EN_CHK : pps_pkg::S_STATUS;
			pps_pkg::S_EN_CHK:
				st_d = (e_addr == addr_q) ? pps_pkg::S_STATUS : pps_pkg::S_EN_RD;
			pps_pkg::S_STATUS: if (out_free) st_d = pps_pkg::S_HOLD;
			pps_pkg::S_HOLD:   st_d = pps_pkg::S_IDLE;
			default:           st_d = pps_pkg::S_IDLE;
		endcase
	end

	// a result is loaded into the output register
	logic ov_set;
	always_comb begin
		ov_set = 1'b0;
		unique case (st_q)
			pps_pkg::S_PAGE:   ov_set = out_free && page_fire;
			pps_pkg::S_TOUCH:  ov_set = out_free && left_q != 8'd0 && touch_fire;
			pps_pkg::S_RR_CHK: ov_set = out_free && e_en && pps_pkg::is_due(now_q, e_due);
			pps_pkg::S_WAIT,
			pps_pkg::S_STATUS: ov_set = out_free;
			default: ;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[SW-1:0];
		mem_wd = rd_s1;
		mem_ra = idx_q[SW-1:0];
		unique case (st_q)
			pps_pkg::S_RR_RD: mem_ra = rr_wrap[SW-1:0];
			pps_pkg::S_RR_CHK: begin
				mem_wa = idx_q[SW-1:0];
				mem_wd = {e_en, e_addr, e_words, e_per, now_q + e_per};
				mem_we = out_free && e_en && pps_pkg::is_due(now_q, e_due);
			end
			pps_pkg::S_STATUS: begin
				mem_wa = used_q[SW-1:0];
				mem_wd = {1'b1, addr_q, words_q, period_q, now_q};
				mem_we = out_free && mode_q == pps_pkg::MODE_ADD && words_q != 8'd0
					&& period_q != 32'd0 && used_q < FullCnt;
			end
			pps_pkg::S_EN_CHK: begin
				mem_wd = {on_q, e_addr, e_words, e_per, now_q};
				mem_we = (e_addr == addr_q);
			end
			default: ;
		endcase
	end

	// sequencer state, output valid flag, configuration registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pps_pkg::S_IDLE;
			ov_q <= 1'b0;
			page_on_q <= 1'b0; touch_on_q <= 1'b0;
			page_per_q <= '0; touch_per_q <= '0;
			budget_q <= 8'd1; def_wait_q <= 32'd10; touch_addr_q <= '0;
			page_armed_q <= 1'b1; touch_armed_q <= 1'b1;
			page_due_q <= '0; touch_due_q <= '0;
			used_q <= '0; rr_q <= '0;
			idx_q <= '0; chk_q <= '0; left_q <= '0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_set || (ov_q && !out_ready);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pps_pkg::REG_PAGE_ON:     page_on_q <= cfg_data[0];
					pps_pkg::REG_PAGE_PERIOD: begin
						page_per_q <= cfg_data; page_armed_q <= 1'b1;
					end
					pps_pkg::REG_TOUCH_ON:    touch_on_q <= cfg_data[0];
					pps_pkg::REG_TOUCH_PER: begin
						touch_per_q <= cfg_data; touch_armed_q <= 1'b1;
					end
					pps_pkg::REG_BUDGET:      budget_q <= cfg_data[7:0];
					pps_pkg::REG_DEF_WAIT:    def_wait_q <= cfg_data;
					pps_pkg::REG_TOUCH_ADDR:  touch_addr_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (st_q)
				pps_pkg::S_IDLE: begin
					idx_q <= '0; chk_q <= '0;
					left_q <= (budget_q == 8'd0) ? 8'd1 : budget_q;
				end
				pps_pkg::S_PAGE: if (out_free && page_fire) begin
					page_due_q <= now_q + page_per_q;
					page_armed_q <= 1'b0; left_q <= left_q - 8'd1;
				end
				pps_pkg::S_TOUCH: if (out_free && left_q != 8'd0 && touch_fire) begin
					touch_due_q <= now_q + touch_per_q;
					touch_armed_q <= 1'b0; left_q <= left_q - 8'd1;
				end
				pps_pkg::S_RR_RD: begin
					if (left_q != 8'd0 && chk_q < used_q) begin
						idx_q <= rr_wrap; rr_q <= rr_wrap + CW'(1);
						chk_q <= chk_q + CW'(1);
					end else idx_q <= '0;
				end
				pps_pkg::S_RR_CHK: if (out_free && e_en && pps_pkg::is_due(now_q, e_due)) begin
					left_q <= left_q - 8'd1;
				end
				pps_pkg::S_MW_RD: ;
				pps_pkg::S_MW_CHK: idx_q <= idx_q + CW'(1);
				pps_pkg::S_WAIT: ;
				pps_pkg::S_EN_RD: ;
				pps_pkg::S_EN_CHK: if (e_addr != addr_q) idx_q <= idx_q + CW'(1);
				pps_pkg::S_STATUS: if (out_free) begin
					if (mode_q == pps_pkg::MODE_ADD && words_q != 8'd0
						&& period_q != 32'd0 && used_q < FullCnt)
						used_q <= used_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// item and payload registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			pps_pkg::S_IDLE: begin
				mode_q <= mode; now_q <= now_time; addr_q <= watch_addr;
				words_q <= watch_words; period_q <= watch_period;
				on_q <= watch_on;
				stat_q <= pps_pkg::ST_BAD;
				found_q <= busy_hint; wait_q <= def_wait_q;
			end
			pps_pkg::S_PAGE: if (out_free) begin
				kind_q <= pps_pkg::KIND_PAGE; raddr_q <= '0; rwords_q <= '0;
				wt_q <= '0; ostat_q <= pps_pkg::ST_OK; last_q <= 1'b0;
			end
			pps_pkg::S_TOUCH: if (out_free) begin
				kind_q <= pps_pkg::KIND_TOUCH; raddr_q <= touch_addr_q;
				rwords_q <= pps_pkg::TouchWords;
				wt_q <= '0; ostat_q <= pps_pkg::ST_OK; last_q <= 1'b0;
			end
			pps_pkg::S_RR_RD: begin
				// fold page and touch into the minimum before the table walk
				if (!(left_q != 8'd0 && chk_q < used_q)) begin
					if (page_on_q && touch_on_q) begin
						if ((!found_q || pt < wait_q) && pt <= tt) wait_q <= pt;
						else if (!found_q || tt < wait_q) wait_q <= tt;
						found_q <= 1'b1;
					end else if (page_on_q) begin
						if (!found_q || pt < wait_q) wait_q <= pt;
						found_q <= 1'b1;
					end else if (touch_on_q) begin
						if (!found_q || tt < wait_q) wait_q <= tt;
						found_q <= 1'b1;
					end
				end
			end
			pps_pkg::S_RR_CHK: if (out_free) begin
				kind_q <= pps_pkg::KIND_WATCH; raddr_q <= e_addr; rwords_q <= e_words;
				wt_q <= '0; ostat_q <= pps_pkg::ST_OK; last_q <= 1'b0;
			end
			pps_pkg::S_MW_CHK: if (e_en) begin
				if (!found_q || e_left < wait_q) wait_q <= e_left;
				found_q <= 1'b1;
			end
			pps_pkg::S_WAIT: if (out_free) begin
				kind_q <= pps_pkg::KIND_WAIT; raddr_q <= '0; rwords_q <= '0;
				wt_q <= found_q ? wait_q : def_wait_q;
				ostat_q <= pps_pkg::ST_OK; last_q <= 1'b1;
			end
			pps_pkg::S_EN_CHK: if (e_addr == addr_q) stat_q <= pps_pkg::ST_OK;
			pps_pkg::S_STATUS: if (out_free) begin
				kind_q <= pps_pkg::KIND_STATUS; raddr_q <= '0; rwords_q <= '0;
				wt_q <= '0; last_q <= 1'b1;
				if (mode_q == pps_pkg::MODE_ADD)
					ostat_q <= (words_q == 8'd0 || period_q == 32'd0) ? pps_pkg::ST_BAD
						: (used_q >= FullCnt) ? pps_pkg::ST_FULL : pps_pkg::ST_OK;
				else if (mode_q == pps_pkg::MODE_EN) ostat_q <= stat_q;
				else ostat_q <= pps_pkg::ST_BAD;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/pps_checker.sv
// Port checker for the periodic poll scheduler, bound to the top level
`default_nettype none
`include "periodic_poll_scheduler_macros.svh"
module pps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] kind,
	input wire logic [1:0] status,
	input wire logic       last
);
	`PPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind))
	`PPS_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, kind <= pps_pkg::KIND_STATUS)
	`PPS_ASSERT_IMP(a_wait_last, clk, arst_n, out_valid && kind == pps_pkg::KIND_WAIT, last)
	`PPS_ASSERT_IMP(a_status_last, clk, arst_n, out_valid && kind == pps_pkg::KIND_STATUS, last && status <= pps_pkg::ST_FULL)
	`PPS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind periodic_poll_scheduler pps_checker u_pps_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
	.status(status), .last(last)
);
`default_nettype wire
